// ----- rtl/cpt_pkg.sv -----
`timescale 1ns / 1ps
package cpt_pkg;

  // Fixed field widths of the request and result ports
  localparam int unsigned REQ_W   = 2;
  localparam int unsigned ENT_W   = 9;
  localparam int unsigned COMP_W  = 3;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned QUERY_W = 8;
  localparam int unsigned TOTAL_W = 10;

  // Default sizing of the table
  localparam int unsigned DEF_MAX_ENTITIES   = 512;
  localparam int unsigned DEF_NUM_COMPONENTS = 8;
  localparam int unsigned DEF_PAYLOAD_BITS   = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_GET    = 2'd2,
    REQ_COUNT  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_COUNT
  } cpt_state_e;

endpackage

// ----- rtl/cpt_ram.sv -----
`timescale 1ns / 1ps
module cpt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512,
  parameter int unsigned AW    = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cpt_ctrl.sv -----
`timescale 1ns / 1ps
module cpt_ctrl import cpt_pkg::*; #(
  parameter int unsigned MAX_ENTITIES   = DEF_MAX_ENTITIES,
  parameter int unsigned NUM_COMPONENTS = DEF_NUM_COMPONENTS,
  parameter int unsigned PAYLOAD_BITS   = DEF_PAYLOAD_BITS,
  parameter int unsigned EW             = $clog2(MAX_ENTITIES),
  parameter int unsigned AW             = $clog2(MAX_ENTITIES * NUM_COMPONENTS)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic [REQ_W-1:0]          req_type_i,
  input  logic [ENT_W-1:0]          entity_i,
  input  logic [COMP_W-1:0]         component_i,
  input  logic [DATA_W-1:0]         payload_i,
  input  logic [QUERY_W-1:0]        query_mask_i,
  output logic [EW-1:0]             pres_addr_o,
  output logic                      pres_we_o,
  output logic [NUM_COMPONENTS-1:0] pres_wdata_o,
  input  logic [NUM_COMPONENTS-1:0] pres_rdata_i,
  output logic [AW-1:0]             pay_addr_o,
  output logic                      pay_we_o,
  output logic [PAYLOAD_BITS-1:0]   pay_wdata_o,
  input  logic [PAYLOAD_BITS-1:0]   pay_rdata_i,
  output logic                      done_o,
  output logic                      status_o,
  output logic [ENT_W-1:0]          new_entity_o,
  output logic                      present_o,
  output logic [DATA_W-1:0]         payload_out_o,
  output logic [TOTAL_W-1:0]        match_count_o,
  output logic [TOTAL_W-1:0]        entity_total_o
);

  localparam int unsigned CW = $clog2(MAX_ENTITIES + 1);
  localparam int unsigned PW = (NUM_COMPONENTS > QUERY_W) ? NUM_COMPONENTS : QUERY_W;
  localparam logic [QUERY_W-1:0] QMASK = (NUM_COMPONENTS >= QUERY_W) ? '1 :
                                         QUERY_W'((1 << NUM_COMPONENTS) - 1);

  cpt_state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] acc_q, acc_d;
  logic          done_q, done_d;
  req_e          req_q, req_d;
  logic [EW-1:0] ent_q, ent_d;
  logic [COMP_W-1:0] comp_q, comp_d;
  logic          ok_q, ok_d;
  logic [QUERY_W-1:0] query_q, query_d;

  logic                 status_q, status_d;
  logic [ENT_W-1:0]     new_q, new_d;
  logic                 present_q, present_d;
  logic [DATA_W-1:0]    payout_q, payout_d;
  logic [TOTAL_W-1:0]   match_q, match_d;
  logic [TOTAL_W-1:0]   total_q, total_d;

  logic                      accept;
  logic                      ent_ok;
  logic                      comp_ok;
  logic                      query_ok;
  logic [EW-1:0]             ent_addr;
  logic [NUM_COMPONENTS-1:0] comp_onehot;
  logic                      bit_set;
  logic [PW-1:0]             pres_wide;
  logic                      hit;
  logic [CW-1:0]             acc_hit;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign ent_ok   = 32'(entity_i) < 32'(MAX_ENTITIES);
  assign comp_ok  = 32'(component_i) < 32'(NUM_COMPONENTS);
  assign query_ok = (query_mask_i & ~QMASK) == '0;
  assign ent_addr = EW'(entity_i);

  // The payload store is written straight away; only presence needs a read first.
  assign pay_addr_o  = AW'(32'(ent_addr) * 32'(NUM_COMPONENTS) + 32'(component_i));
  assign pay_we_o    = accept && (req_type_i == REQ_INSERT) && ent_ok && comp_ok;
  assign pay_wdata_o = PAYLOAD_BITS'(payload_i);

  assign comp_onehot = NUM_COMPONENTS'(1) << comp_q;
  assign bit_set     = |(pres_rdata_i & comp_onehot);
  assign pres_wide   = PW'(pres_rdata_i);
  assign hit         = (pres_wide[QUERY_W-1:0] & query_q) == query_q;
  assign acc_hit     = acc_q + CW'(hit);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    done_d    = 1'b0;
    req_d     = req_q;
    ent_d     = ent_q;
    comp_d    = comp_q;
    ok_d      = ok_q;
    query_d   = query_q;
    status_d  = status_q;
    new_d     = new_q;
    present_d = present_q;
    payout_d  = payout_q;
    match_d   = match_q;
    total_d   = total_q;
    busy_o    = 1'b1;
    pres_addr_o  = ent_q;
    pres_we_o    = 1'b0;
    pres_wdata_o = '0;

    case (state_q)
      ST_CLEAR: begin
        pres_addr_o = idx_q[EW-1:0];
        pres_we_o   = 1'b1;
        idx_d       = idx_q + CW'(1);
        if (idx_q[EW-1:0] == EW'(MAX_ENTITIES - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        busy_o      = 1'b0;
        pres_addr_o = (req_type_i == REQ_COUNT) ? '0 : ent_addr;
        if (start_i) begin
          req_d     = req_e'(req_type_i);
          ent_d     = ent_addr;
          comp_d    = component_i;
          ok_d      = ent_ok && comp_ok;
          query_d   = query_mask_i;
          status_d  = 1'b0;
          new_d     = '0;
          present_d = 1'b0;
          payout_d  = '0;
          match_d   = '0;
          total_d   = TOTAL_W'(cnt_q);
          case (req_e'(req_type_i))
            REQ_CREATE: begin
              done_d = 1'b1;
              if (cnt_q == CW'(MAX_ENTITIES)) begin
                status_d = 1'b1;
              end else begin
                new_d   = ENT_W'(cnt_q);
                cnt_d   = cnt_q + CW'(1);
                total_d = TOTAL_W'(cnt_q + CW'(1));
              end
            end
            REQ_INSERT, REQ_GET: begin
              state_d = ST_ACCESS;
            end
            REQ_COUNT: begin
              // The walk starts with entity zero, read in this very cycle.
              if (query_ok && (cnt_q != '0)) begin
                idx_d   = CW'(1);
                acc_d   = '0;
                state_d = ST_COUNT;
              end else begin
                done_d = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (req_q == REQ_INSERT) begin
          pres_we_o    = ok_q;
          pres_wdata_o = pres_rdata_i | comp_onehot;
        end else begin
          present_d = ok_q && bit_set;
          payout_d  = (ok_q && bit_set) ? DATA_W'(pay_rdata_i) : '0;
        end
      end

      ST_COUNT: begin
        if (idx_q < cnt_q) begin
          pres_addr_o = idx_q[EW-1:0];
          idx_d       = idx_q + CW'(1);
          acc_d       = acc_hit;
        end else begin
          match_d = TOTAL_W'(acc_hit);
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (!accept && (state_q == ST_IDLE)) begin
      req_d = req_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    req_q     <= req_d;
    ent_q     <= ent_d;
    comp_q    <= comp_d;
    ok_q      <= ok_d;
    query_q   <= query_d;
    status_q  <= status_d;
    new_q     <= new_d;
    present_q <= present_d;
    payout_q  <= payout_d;
    match_q   <= match_d;
    total_q   <= total_d;
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign new_entity_o   = new_q;
  assign present_o      = present_q;
  assign payload_out_o  = payout_q;
  assign match_count_o  = match_q;
  assign entity_total_o = total_q;

endmodule

// ----- rtl/component_presence_table.sv -----
`timescale 1ns / 1ps
// Create: result strobe in the cycle after acceptance; insert and get: strobe after the access
// state, where insert ends the read-modify-write of the presence memory. Count: one presence word
// read per cycle for n created entities; as for create if the mask names an unknown kind or n is 0.
// A new request is taken in the cycle its predecessor's result is shown; the receiver cannot stall.
// After reset the entity counter is zero and busy stays high while the presence memory is swept
// to zero, one word for each of the MAX_ENTITIES (512 by default) entities.
module component_presence_table import cpt_pkg::*; #(
  parameter int unsigned MAX_ENTITIES   = DEF_MAX_ENTITIES,
  parameter int unsigned NUM_COMPONENTS = DEF_NUM_COMPONENTS,
  parameter int unsigned PAYLOAD_BITS   = DEF_PAYLOAD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [ENT_W-1:0]   entity_i,
  input  logic [COMP_W-1:0]  component_i,
  input  logic [DATA_W-1:0]  payload_i,
  input  logic [QUERY_W-1:0] query_mask_i,
  output logic               done_o,
  output logic               status_o,
  output logic [ENT_W-1:0]   new_entity_o,
  output logic               present_o,
  output logic [DATA_W-1:0]  payload_out_o,
  output logic [TOTAL_W-1:0] match_count_o,
  output logic [TOTAL_W-1:0] entity_total_o
);

  localparam int unsigned EW = $clog2(MAX_ENTITIES);
  localparam int unsigned AW = $clog2(MAX_ENTITIES * NUM_COMPONENTS);

  logic [EW-1:0]             pres_addr;
  logic                      pres_we;
  logic [NUM_COMPONENTS-1:0] pres_wdata;
  logic [NUM_COMPONENTS-1:0] pres_rdata;
  logic [AW-1:0]             pay_addr;
  logic                      pay_we;
  logic [PAYLOAD_BITS-1:0]   pay_wdata;
  logic [PAYLOAD_BITS-1:0]   pay_rdata;

  cpt_ctrl #(
    .MAX_ENTITIES   (MAX_ENTITIES),
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .PAYLOAD_BITS   (PAYLOAD_BITS),
    .EW             (EW),
    .AW             (AW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .req_type_i     (req_type_i),
    .entity_i       (entity_i),
    .component_i    (component_i),
    .payload_i      (payload_i),
    .query_mask_i   (query_mask_i),
    .pres_addr_o    (pres_addr),
    .pres_we_o      (pres_we),
    .pres_wdata_o   (pres_wdata),
    .pres_rdata_i   (pres_rdata),
    .pay_addr_o     (pay_addr),
    .pay_we_o       (pay_we),
    .pay_wdata_o    (pay_wdata),
    .pay_rdata_i    (pay_rdata),
    .done_o         (done_o),
    .status_o       (status_o),
    .new_entity_o   (new_entity_o),
    .present_o      (present_o),
    .payload_out_o  (payload_out_o),
    .match_count_o  (match_count_o),
    .entity_total_o (entity_total_o)
  );

  cpt_ram #(
    .WIDTH (NUM_COMPONENTS),
    .DEPTH (MAX_ENTITIES),
    .AW    (EW)
  ) u_presence_ram (
    .clk_i   (clk_i),
    .we_i    (pres_we),
    .addr_i  (pres_addr),
    .wdata_i (pres_wdata),
    .rdata_o (pres_rdata)
  );

  cpt_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (MAX_ENTITIES * NUM_COMPONENTS),
    .AW    (AW)
  ) u_payload_ram (
    .clk_i   (clk_i),
    .we_i    (pay_we),
    .addr_i  (pay_addr),
    .wdata_i (pay_wdata),
    .rdata_o (pay_rdata)
  );

endmodule

// ----- rtl/cpt_checker.sv -----
`timescale 1ns / 1ps
module cpt_props import cpt_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [REQ_W-1:0]   req_type_i,
  input logic [ENT_W-1:0]   entity_i,
  input logic [COMP_W-1:0]  component_i,
  input logic [DATA_W-1:0]  payload_i,
  input logic [QUERY_W-1:0] query_mask_i,
  input logic               done_o,
  input logic               status_o,
  input logic [ENT_W-1:0]   new_entity_o,
  input logic               present_o,
  input logic [DATA_W-1:0]  payload_out_o,
  input logic [TOTAL_W-1:0] match_count_o,
  input logic [TOTAL_W-1:0] entity_total_o
);

  // A result only ever follows an accepted transaction or work in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(start && !busy) || $past(busy)))
    else $error("result strobe without a pending transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_type_i == REQ_CREATE)) |=> (done_o && !busy))
    else $error("create result not given in the following cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((req_type_i == REQ_INSERT) || (req_type_i == REQ_GET)))
      |=> (busy && !done_o) ##1 done_o)
    else $error("insert or get result not given after the memory access");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> ((new_entity_o == '0) && !present_o && (match_count_o == '0)))
    else $error("table full result carries other fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !present_o) |-> (payload_out_o == '0))
    else $error("payload given for an absent component");

endmodule

bind component_presence_table cpt_props u_cpt_props (.*);

// ----- tb/sv/cpt_checker.sv -----
`timescale 1ns / 1ps
module cpt_checker import cpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [REQ_W-1:0]   req_type_i,
  input  logic [ENT_W-1:0]   entity_i,
  input  logic [COMP_W-1:0]  component_i,
  input  logic [DATA_W-1:0]  payload_i,
  input  logic [QUERY_W-1:0] query_mask_i,
  input  logic               done_i,
  input  logic               status_i,
  input  logic [ENT_W-1:0]   new_entity_i,
  input  logic               present_i,
  input  logic [DATA_W-1:0]  payload_out_i,
  input  logic [TOTAL_W-1:0] match_count_i,
  input  logic [TOTAL_W-1:0] entity_total_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);

  localparam int unsigned NumEnt   = DEF_MAX_ENTITIES;
  localparam int unsigned NumComp  = DEF_NUM_COMPONENTS;
  localparam int unsigned DataBits = DEF_PAYLOAD_BITS;

  typedef struct packed {
    logic               status;
    logic [ENT_W-1:0]   new_entity;
    logic               present;
    logic [DATA_W-1:0]  payload_out;
    logic [TOTAL_W-1:0] match_count;
    logic [TOTAL_W-1:0] entity_total;
  } response_t;

  logic [NumComp-1:0] presence_q [NumEnt];
  logic [DATA_W-1:0]  payload_q [NumEnt*NumComp];
  int unsigned        entities_created = 0;
  response_t          pending_responses [$];
  int unsigned        mismatches = 0;
  int unsigned        reported = 0;

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  function automatic logic [DATA_W-1:0] width_mask(int unsigned bits);
    if (bits >= 64) return '1;
    return (64'd1 << bits) - 64'd1;
  endfunction

  // Applies one request to the table copy and returns the response it should give.
  function automatic response_t compute_response(logic [REQ_W-1:0] req,
                                                 logic [ENT_W-1:0] ent,
                                                 logic [COMP_W-1:0] comp,
                                                 logic [DATA_W-1:0] data,
                                                 logic [QUERY_W-1:0] query);
    response_t   rsp;
    bit          ent_ok;
    bit          comp_ok;
    int unsigned hits;
    logic [63:0] want_bits;
    rsp     = '0;
    hits    = 0;
    ent_ok  = 32'(ent) < NumEnt;
    comp_ok = 32'(comp) < NumComp;
    case (req_e'(req))
      REQ_CREATE: begin
        if (entities_created >= NumEnt) begin
          rsp.status = 1'b1;
        end else begin
          rsp.new_entity = entities_created[ENT_W-1:0];
          entities_created++;
        end
      end
      REQ_INSERT: begin
        if (ent_ok && comp_ok) begin
          payload_q[32'(ent) * NumComp + 32'(comp)] = data & width_mask(DataBits);
          presence_q[ent][comp] = 1'b1;
        end
      end
      REQ_GET: begin
        if (ent_ok && comp_ok && presence_q[ent][comp]) begin
          rsp.present     = 1'b1;
          rsp.payload_out = payload_q[32'(ent) * NumComp + 32'(comp)];
        end
      end
      default: begin
        want_bits = 64'(query);
        // A mask naming a kind beyond the table matches no entity at all.
        if ((want_bits & ~width_mask(NumComp)) == 64'd0) begin
          for (int i = 0; i < entities_created && i < NumEnt; i++) begin
            if ((64'(presence_q[i]) & want_bits) == want_bits) hits++;
          end
        end
        rsp.match_count = hits[TOTAL_W-1:0];
      end
    endcase
    rsp.entity_total = entities_created[TOTAL_W-1:0];
    return rsp;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (reported < 10) begin
        reported++;
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $realtime, name, exp_v,
                 act_v);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    response_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumEnt; i++) presence_q[i] = '0;
      entities_created = 0;
      pending_responses.delete();
    end else begin
      // The result shown in this cycle belongs to an earlier transaction, so it is
      // checked before a request taken at the same edge is queued.
      if (done_i) begin
        if (pending_responses.size() == 0) begin
          mismatches++;
          if (reported < 10) begin
            reported++;
            $display("%0t: result strobe with no transaction outstanding", $realtime);
          end
        end else begin
          want = pending_responses.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("new_entity", 64'(want.new_entity), 64'(new_entity_i));
          check_field("present", 64'(want.present), 64'(present_i));
          check_field("payload_out", want.payload_out, payload_out_i);
          check_field("match_count", 64'(want.match_count), 64'(match_count_i));
          check_field("entity_total", 64'(want.entity_total), 64'(entity_total_i));
        end
      end
      if (start_i && !busy_i) begin
        pending_responses.push_back(compute_response(req_type_i, entity_i, component_i,
                                                     payload_i, query_mask_i));
      end
    end
    errors_o  <= mismatches;
    pending_o <= pending_responses.size();
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import cpt_pkg::*;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned RandomItems = 2000;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   req_type;
  logic [ENT_W-1:0]   entity;
  logic [COMP_W-1:0]  component;
  logic [DATA_W-1:0]  payload;
  logic [QUERY_W-1:0] query_mask;
  logic               done_o;
  logic               status_o;
  logic [ENT_W-1:0]   new_entity_o;
  logic               present_o;
  logic [DATA_W-1:0]  payload_out_o;
  logic [TOTAL_W-1:0] match_count_o;
  logic [TOTAL_W-1:0] entity_total_o;
  int unsigned        errors;
  int unsigned        pending;

  bit                 gaps_on = 1'b1;
  int unsigned        created = 0;

  component_presence_table i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type),
    .entity_i       (entity),
    .component_i    (component),
    .payload_i      (payload),
    .query_mask_i   (query_mask),
    .done_o         (done_o),
    .status_o       (status_o),
    .new_entity_o   (new_entity_o),
    .present_o      (present_o),
    .payload_out_o  (payload_out_o),
    .match_count_o  (match_count_o),
    .entity_total_o (entity_total_o)
  );

  cpt_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .req_type_i     (req_type),
    .entity_i       (entity),
    .component_i    (component),
    .payload_i      (payload),
    .query_mask_i   (query_mask),
    .done_i         (done_o),
    .status_i       (status_o),
    .new_entity_i   (new_entity_o),
    .present_i      (present_o),
    .payload_out_i  (payload_out_o),
    .match_count_i  (match_count_o),
    .entity_total_i (entity_total_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Returns after an edge at which busy is seen low, so the next call can keep
  // start high without lowering it in between.
  task automatic issue(req_e req, logic [ENT_W-1:0] ent, logic [COMP_W-1:0] comp,
                       logic [DATA_W-1:0] data, logic [QUERY_W-1:0] mask);
    if (gaps_on && $urandom_range(0, 99) < 23) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type   <= req;
    entity     <= ent;
    component  <= comp;
    payload    <= data;
    query_mask <= mask;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (req == REQ_CREATE && created < DEF_MAX_ENTITIES) created++;
  endtask

  // Mostly a small set of entities so that presence words fill up and counts match.
  function automatic logic [ENT_W-1:0] pick_entity();
    int unsigned sel = $urandom_range(0, 3);
    if (sel < 2) return ENT_W'($urandom_range(0, 15));
    if (sel == 2 && created > 0) return ENT_W'($urandom_range(0, created - 1));
    return ENT_W'($urandom_range(0, 511));
  endfunction

  function automatic logic [DATA_W-1:0] pick_payload();
    int unsigned sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [QUERY_W-1:0] pick_mask();
    int unsigned sel = $urandom_range(0, 19);
    if (sel < 2) return '0;
    if (sel < 10) return QUERY_W'(1) << $urandom_range(0, 7);
    if (sel < 15) return (QUERY_W'(1) << $urandom_range(0, 7)) |
                         (QUERY_W'(1) << $urandom_range(0, 7));
    return QUERY_W'($urandom);
  endfunction

  initial begin
    int unsigned        pick;
    logic [ENT_W-1:0]   ent;
    logic [COMP_W-1:0]  comp;
    logic [DATA_W-1:0]  data;
    logic [QUERY_W-1:0] mask;
    logic [ENT_W-1:0]   last_ent;
    logic [COMP_W-1:0]  last_comp;
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type   = REQ_CREATE;
    entity     = '0;
    component  = '0;
    payload    = '0;
    query_mask = '0;
    last_ent   = '0;
    last_comp  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, then a handful of entities with payloads at the field extremes.
    issue(REQ_COUNT, '0, '0, '0, '0);
    issue(REQ_GET, '0, '0, '0, '0);
    repeat (3) issue(REQ_CREATE, '0, '0, '0, '0);
    issue(REQ_INSERT, 9'd0, 3'd0, '0, '0);
    issue(REQ_INSERT, 9'd0, 3'd7, '1, '0);
    issue(REQ_INSERT, 9'd511, 3'd7, 64'hA5A5_5A5A_0F0F_F0F0, '0);
    issue(REQ_INSERT, 9'd1, 3'd0, 64'd1, '0);
    issue(REQ_GET, 9'd0, 3'd0, '0, '0);
    issue(REQ_GET, 9'd0, 3'd7, '0, '0);
    issue(REQ_GET, 9'd511, 3'd7, '0, '0);
    issue(REQ_GET, 9'd511, 3'd0, '0, '0);
    issue(REQ_GET, 9'd1, 3'd0, '0, '0);
    // Overwriting keeps the presence bit and replaces the payload.
    issue(REQ_INSERT, 9'd0, 3'd0, 64'h8000_0000_0000_0001, '0);
    issue(REQ_GET, 9'd0, 3'd0, '0, '0);
    issue(REQ_COUNT, '0, '0, '0, 8'h00);
    issue(REQ_COUNT, '0, '0, '0, 8'h01);
    issue(REQ_COUNT, '0, '0, '0, 8'h81);
    issue(REQ_COUNT, '0, '0, '0, 8'hFF);
    issue(REQ_COUNT, '0, '0, '0, 8'h80);

    // Creates are frequent enough that the table fills and later creates report full.
    for (int n = 0; n < RandomItems; n++) begin
      gaps_on = (n < 900 || n >= 1200);
      pick    = $urandom_range(0, 99);
      ent     = pick_entity();
      comp    = COMP_W'($urandom_range(0, 7));
      data    = pick_payload();
      mask    = pick_mask();
      if (pick < 35) begin
        issue(REQ_CREATE, ent, comp, data, mask);
      end else if (pick < 62) begin
        issue(REQ_INSERT, ent, comp, data, mask);
        last_ent  = ent;
        last_comp = comp;
      end else if (pick < 87) begin
        if ($urandom_range(0, 99) < 40) begin
          ent  = last_ent;
          comp = last_comp;
        end
        issue(REQ_GET, ent, comp, data, mask);
      end else begin
        issue(REQ_COUNT, ent, comp, data, mask);
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DEF_MAX_ENTITIES + 8) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Ends the run if neither a request nor a result moves for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Verification failed");
    $finish;
  end

endmodule
